FILE: rtl/fsf_pkg.sv
// Shared types, codes and helpers of the fixed-string line filter.
package fsf_pkg;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int PLEN_W        = 5;
    localparam int CHUNK_DATA_W  = 64;
    localparam int CHUNK_COUNT_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] CR_CODE      = 8'd13;
    localparam logic [7:0] NUL_CODE     = 8'd0;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [PLEN_W-1:0]     pattern_length;
    } t_pattern_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WAIT,
        BK_EMIT
    } t_back_state;

    // Byte i of the pattern; bytes 0 to 7 live in the low register.
    function automatic logic [7:0] pattern_byte(input t_pattern_cfg cfg,
                                                input logic [3:0] idx);
        logic [2*CFG_DATA_W-1:0] both;
        both = {cfg.pattern_high, cfg.pattern_low};
        return both[{idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/fsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fsf_line_queue.sv
// Two-entry queue of finished matched lines, one entry for each line bank.
module fsf_line_queue #(
    parameter int WIDTH = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_head
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rptr];

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("line queue pushed while full");

endmodule

FILE: rtl/fsf_front.sv
// Front end: takes bytes, writes lines into the store and tracks the pattern window.
module fsf_front
    import fsf_pkg::*;
#(
    parameter int LINE_BYTES    = 256,
    parameter int PATTERN_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_pattern_cfg                        i_cfg,
    input  logic                                i_push,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_stream_end,
    output logic                                o_full,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [$clog2(LINE_BYTES+1)+1:0]     o_q_data,
    output logic                                o_ram_we,
    output logic [$clog2(LINE_BYTES):0]         o_ram_waddr,
    output logic [7:0]                          o_ram_wdata
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int LA = $clog2(LINE_BYTES);
    localparam int FW = $clog2(PATTERN_BYTES + 1);
    localparam int PI = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_win [PATTERN_BYTES];
    logic [7:0]    win_new [PATTERN_BYTES];
    logic [FW-1:0] r_fill, n_fill, fill_new;
    logic          r_matched, n_matched;
    logic          r_overflow, n_overflow;
    logic          r_bank, n_bank;

    logic          accept;
    logic          is_term;
    logic          line_end;
    logic          hit;
    logic          same;
    logic [4:0]    widx;
    logic [LW-1:0] len_new;
    logic          ovf_new;
    logic          matched_new;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign is_term  = (i_text_byte == NEWLINE_CODE) || (i_text_byte == NUL_CODE);
    assign line_end = is_term || i_stream_end;

    always_comb begin
        win_new[0] = i_text_byte;
        for (int k = 1; k < PATTERN_BYTES; k++) begin
            win_new[k] = r_win[k-1];
        end
        fill_new = (r_fill < FW'(PATTERN_BYTES)) ? r_fill + 1'b1 : r_fill;
    end

    // The newest byte sits at window slot 0, so pattern byte i meets the
    // slot that lies length-1-i bytes back.
    always_comb begin
        same = 1'b1;
        widx = 5'd0;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if (5'(i) < i_cfg.pattern_length) begin
                widx = i_cfg.pattern_length - 5'd1 - 5'(i);
                if (pattern_byte(i_cfg, 4'(i)) != win_new[widx[PI-1:0]]) begin
                    same = 1'b0;
                end
            end
        end
        if (i_cfg.pattern_length == 5'd0) begin
            hit = 1'b1;
        end else if ((6'(i_cfg.pattern_length) <= 6'(PATTERN_BYTES))
                     && (6'(fill_new) >= 6'(i_cfg.pattern_length))) begin
            hit = same;
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = {r_bank, r_len[LA-1:0]};
        o_ram_wdata = i_text_byte;
        len_new     = r_len;
        ovf_new     = r_overflow;
        matched_new = r_matched;
        if (!is_term) begin
            if (r_len < LW'(LINE_BYTES)) begin
                o_ram_we = accept;
                len_new  = r_len + 1'b1;
            end else begin
                ovf_new = 1'b1;
            end
            matched_new = r_matched || hit;
        end

        o_q_push   = 1'b0;
        o_q_data   = {r_bank, ovf_new, len_new};
        n_len      = r_len;
        n_fill     = r_fill;
        n_matched  = r_matched;
        n_overflow = r_overflow;
        n_bank     = r_bank;
        if (accept) begin
            if (line_end) begin
                if ((len_new != '0) && matched_new) begin
                    o_q_push = 1'b1;
                    n_bank   = ~r_bank;
                end
                n_len      = '0;
                n_fill     = '0;
                n_matched  = 1'b0;
                n_overflow = 1'b0;
            end else begin
                n_len      = len_new;
                n_fill     = fill_new;
                n_matched  = matched_new;
                n_overflow = ovf_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_fill     <= '0;
            r_matched  <= 1'b0;
            r_overflow <= 1'b0;
            r_bank     <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_fill     <= n_fill;
            r_matched  <= n_matched;
            r_overflow <= n_overflow;
            r_bank     <= n_bank;
        end
    end

    // Window bytes beyond the fill count never decide a match.
    always_ff @(posedge i_clk) begin
        if (accept && !is_term) begin
            for (int k = 0; k < PATTERN_BYTES; k++) begin
                r_win[k] <= win_new[k];
            end
        end
    end

endmodule

FILE: rtl/fsf_back.sv
// Back end: reads a matched line from its bank and sends it out in chunks with CR LF.
module fsf_back
    import fsf_pkg::*;
#(
    parameter int LINE_BYTES  = 256,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_desc_valid,
    input  logic                            i_desc_bank,
    input  logic                            i_desc_ovf,
    input  logic [$clog2(LINE_BYTES+1)-1:0] i_desc_len,
    output logic                            o_desc_pop,
    output logic [$clog2(LINE_BYTES):0]     o_rd_addr,
    input  logic [7:0]                      i_rd_data,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [CHUNK_DATA_W-1:0]         o_chunk_data,
    output logic [CHUNK_COUNT_W-1:0]        o_chunk_bytes,
    output logic                            o_line_truncated,
    output logic                            o_last_chunk
);

    localparam int LA = $clog2(LINE_BYTES);
    localparam int PW = $clog2(LINE_BYTES + 3);

    t_back_state r_state, n_state;

    logic [PW-1:0]            r_pos, n_pos;
    logic [CHUNK_DATA_W-1:0]  r_asm, n_asm;
    logic [CHUNK_COUNT_W-1:0] r_n, n_n;

    logic                     r_out_valid, n_out_valid;
    logic [CHUNK_DATA_W-1:0]  r_out_data, n_out_data;
    logic [CHUNK_COUNT_W-1:0] r_out_bytes, n_out_bytes;
    logic                     r_out_trunc, n_out_trunc;
    logic                     r_out_last, n_out_last;

    logic [PW-1:0]            total;
    logic [PW-1:0]            pos_inc;
    logic [CHUNK_COUNT_W-1:0] n_inc;
    logic [7:0]               cur_byte;
    logic                     chunk_done;
    logic                     can_load;
    logic                     at_end;
    logic [PW-1:0]            rd_pos;

    assign total      = PW'(i_desc_len) + PW'(2);
    assign pos_inc    = r_pos + 1'b1;
    assign n_inc      = r_n + 1'b1;
    assign chunk_done = (n_inc == CHUNK_COUNT_W'(CHUNK_BYTES)) || (pos_inc == total);
    assign can_load   = !r_out_valid || i_pop;
    assign at_end     = (r_pos == total);

    // Past the stored bytes the line is finished with CR and then LF.
    always_comb begin
        if (r_pos < PW'(i_desc_len)) begin
            cur_byte = i_rd_data;
        end else if (r_pos == PW'(i_desc_len)) begin
            cur_byte = CR_CODE;
        end else begin
            cur_byte = NEWLINE_CODE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_desc_valid) begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (chunk_done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (can_load) begin
                    n_state = at_end ? BK_IDLE : BK_WAIT;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_n         = r_n;
        rd_pos      = r_pos;
        o_desc_pop  = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        n_out_data  = r_out_data;
        n_out_bytes = r_out_bytes;
        n_out_trunc = r_out_trunc;
        n_out_last  = r_out_last;
        unique case (r_state)
            BK_IDLE: begin
                n_pos  = '0;
                n_asm  = '0;
                n_n    = '0;
                rd_pos = '0;
            end
            BK_WAIT: begin
                n_asm  = r_asm | (CHUNK_DATA_W'(cur_byte) << {r_n[2:0], 3'b000});
                n_n    = n_inc;
                n_pos  = pos_inc;
                rd_pos = pos_inc;
            end
            BK_EMIT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_asm;
                    n_out_bytes = r_n;
                    n_out_trunc = i_desc_ovf;
                    n_out_last  = at_end;
                    n_asm       = '0;
                    n_n         = '0;
                    o_desc_pop  = at_end;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    assign o_rd_addr = {i_desc_bank, rd_pos[LA-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_asm       <= n_asm;
        r_n         <= n_n;
        r_out_data  <= n_out_data;
        r_out_bytes <= n_out_bytes;
        r_out_trunc <= n_out_trunc;
        r_out_last  <= n_out_last;
    end

    assign o_empty          = !r_out_valid;
    assign o_chunk_data     = r_out_data;
    assign o_chunk_bytes    = r_out_bytes;
    assign o_line_truncated = r_out_trunc;
    assign o_last_chunk     = r_out_last;

    a_pop_only_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_pop |-> (r_state == BK_EMIT) && at_end && can_load)
        else $error("line released before its last chunk was sent");

    a_chunk_not_overfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_WAIT) |-> (r_n < CHUNK_COUNT_W'(CHUNK_BYTES)))
        else $error("chunk assembly ran past the chunk size");

    a_line_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> i_desc_valid)
        else $error("line descriptor vanished during emission");

endmodule

FILE: rtl/fixed_string_line_filter.sv
// Top level of the fixed-string line filter: configuration registers and wiring.
//
// Bytes enter on the push/full queue port (text_byte, stream_end). A newline,
// a zero byte or stream_end closes the current line; a non-empty line that
// held the configured pattern leaves on the empty/pop port as chunks of up to
// CHUNK_BYTES bytes, the last chunk ending in CR LF and flagged last_chunk.
// The pattern is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// The front end takes one byte per cycle while full is low. Lines live in two banks of the
// line RAM, so one matched line can be emitted while the next is collected;
// full rises while both banks hold lines waiting to go out.
// The back end reads one byte per cycle from the single RAM read port while
// it assembles a chunk, and pauses while it hands each finished chunk on.
// When pop is held low the finished chunk waits in the output register and
// the back end stops, while the front end keeps taking bytes until both
// banks are busy. Reset clears the pattern to empty (match every non-empty
// line), drops any partial line and any waiting output.
module fixed_string_line_filter
    import fsf_pkg::*;
#(
    parameter int LINE_BYTES    = 256,
    parameter int PATTERN_BYTES = 16,
    parameter int CHUNK_BYTES   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     push,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_stream_end,
    output logic                     full,
    output logic                     empty,
    input  logic                     pop,
    output logic [CHUNK_DATA_W-1:0]  o_chunk_data,
    output logic [CHUNK_COUNT_W-1:0] o_chunk_bytes,
    output logic                     o_line_truncated,
    output logic                     o_last_chunk
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int LA = $clog2(LINE_BYTES);
    localparam int DW = LW + 2;

    t_pattern_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:    r_cfg.pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_cfg.pattern_high   <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[PLEN_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    logic          q_push;
    logic [DW-1:0] q_data;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [DW-1:0] q_head;
    logic          ram_we;
    logic [LA:0]   ram_waddr;
    logic [7:0]    ram_wdata;
    logic [LA:0]   ram_raddr;
    logic [7:0]    ram_rdata;

    fsf_front #(
        .LINE_BYTES    (LINE_BYTES),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_text_byte  (i_text_byte),
        .i_stream_end (i_stream_end),
        .o_full       (full),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_data),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    fsf_line_queue #(
        .WIDTH (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    fsf_ram #(
        .WIDTH (8),
        .DEPTH (2 * (2 ** LA))
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsf_back #(
        .LINE_BYTES  (LINE_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_desc_valid     (q_valid),
        .i_desc_bank      (q_head[DW-1]),
        .i_desc_ovf       (q_head[DW-2]),
        .i_desc_len       (q_head[LW-1:0]),
        .o_desc_pop       (q_pop),
        .o_rd_addr        (ram_raddr),
        .i_rd_data        (ram_rdata),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_chunk_data     (o_chunk_data),
        .o_chunk_bytes    (o_chunk_bytes),
        .o_line_truncated (o_line_truncated),
        .o_last_chunk     (o_last_chunk)
    );

endmodule
